// ----- hdl/wbps_pkg.sv -----
// ----------------------------------------------------------------------------
// wbps_pkg
// shared types and constants for the wildcard byte pattern scanner
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int ADDR_W        = 48;
    localparam int COUNT_W       = 32;
    localparam int OFFSET_W      = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int LENGTH_REG_W  = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_COMPARE_MASK = 3'd2,
        REG_PATTERN_LEN  = 3'd3,
        REG_WANTED_MATCH = 3'd4,
        REG_BASE_ADDRESS = 3'd5,
        REG_ADDR_OFFSET  = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [8*PATTERN_BYTES-1:0] pattern;
        logic [PATTERN_BYTES-1:0]   mask;
    } t_match_cfg;

endpackage

// ----- hdl/wbps_matcher.sv -----
// ----------------------------------------------------------------------------
// wbps_matcher
// masked compare of the byte history against the pattern, one byte per lane
// ----------------------------------------------------------------------------
module wbps_matcher #(
    parameter int MAX_PATTERN = 16
) (
    input  wbps_pkg::t_match_cfg                      i_cfg,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]          i_len,
    input  logic [7:0]                                i_hist [MAX_PATTERN],
    output logic                                      o_hit
);
    import wbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    always_comb begin
        logic [LEN_W-1:0] hist_idx;
        logic [7:0]       pat_byte;
        logic             cmp_bit;
        o_hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            hist_idx = i_len - LEN_W'(1) - LEN_W'(i);
            pat_byte = i_cfg.pattern[8*(i % PATTERN_BYTES) +: 8];
            cmp_bit  = i_cfg.mask[i % PATTERN_BYTES] && (i < PATTERN_BYTES);
            if (LEN_W'(i) < i_len && cmp_bit) begin
                if (pat_byte != i_hist[IDX_W'(hist_idx)]) begin
                    o_hit = 1'b0;
                end
            end
        end
    end

endmodule

// ----- hdl/wildcard_byte_pattern_scanner.sv -----
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// nth-match search for a masked byte pattern in a streamed memory image
// ----------------------------------------------------------------------------
// Bytes of an image arrive on the input channel (valid/ready), one per
// transfer, with i_final_byte marking the last one. The block gives at most
// one result per image on the output channel: a found result with the
// address base + start + offset (mod 2^48) when the wanted match ends, or a
// not-found result with address zero on the final byte if none was reported.
// Registers are written through the configuration channel, which is always
// ready; the user makes writes only while the scanner is idle; the block
// itself does not enforce this. Each byte is compared, counted and turned
// into a result while in the input register; the result is registered in the
// output register as the byte moves on. The window compare is combinational,
// so one byte per cycle is sustained unless a stalled receiver holds the
// scanner, which it does only once both input and output registers are full.
// Reset (synchronous, active low) restores the register defaults and clears
// the scan state; after the final byte the scan state clears for the next
// image.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner #(
    parameter int MAX_PATTERN   = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_final_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [wbps_pkg::ADDR_W-1:0]       o_match_address,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import wbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int WIN_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

    // configuration registers
    logic [8*PATTERN_BYTES-1:0] r_pattern;
    logic [PATTERN_BYTES-1:0]   r_mask;
    logic [LENGTH_REG_W-1:0]    r_len;
    logic [COUNT_W-1:0]         r_wanted;
    logic [ADDR_W-1:0]          r_base;
    logic [OFFSET_W-1:0]        r_offset;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;

    // scan state
    logic [7:0]               r_window [WIN_D];
    logic [LEN_W-1:0]         r_fill;
    logic [POSITION_BITS-1:0] r_pos;
    logic [COUNT_W-1:0]       r_seen;
    logic                     r_reported;

    // output register
    logic              r_out_valid;
    logic              r_found;
    logic [ADDR_W-1:0] r_addr;

    logic                     advance;
    logic [LEN_W-1:0]         eff_len;
    logic [LEN_W-1:0]         n_fill;
    logic [7:0]               hist [MAX_PATTERN];
    logic                     hit;
    logic                     counted;
    logic                     take;
    logic                     emit;
    logic [POSITION_BITS-1:0] start_pos;
    logic [ADDR_W-1:0]        n_addr;
    t_match_cfg               match_cfg;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_mask    <= '1;
            r_len     <= LENGTH_REG_W'(1);
            r_wanted  <= '0;
            r_base    <= '0;
            r_offset  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_PATTERN_LOW:  r_pattern[63:0]   <= i_cfg_data;
                REG_PATTERN_HIGH: r_pattern[127:64] <= i_cfg_data;
                REG_COMPARE_MASK: r_mask   <= i_cfg_data[PATTERN_BYTES-1:0];
                REG_PATTERN_LEN:  r_len    <= i_cfg_data[LENGTH_REG_W-1:0];
                REG_WANTED_MATCH: r_wanted <= i_cfg_data[COUNT_W-1:0];
                REG_BASE_ADDRESS: r_base   <= i_cfg_data[ADDR_W-1:0];
                REG_ADDR_OFFSET:  r_offset <= i_cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // lengths of zero and above the window size are clamped
    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(r_len) > MAX_PATTERN) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = LEN_W'(r_len);
        end
    end

    assign n_fill = (32'(r_fill) < MAX_PATTERN) ? r_fill + LEN_W'(1) : r_fill;

    always_comb begin
        hist[0] = r_in_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            hist[j] = r_window[j-1];
        end
    end

    assign match_cfg.pattern = r_pattern;
    assign match_cfg.mask    = r_mask;

    wbps_matcher #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_matcher (
        .i_cfg  (match_cfg),
        .i_len  (eff_len),
        .i_hist (hist),
        .o_hit  (hit)
    );

    assign counted   = !r_reported && (n_fill >= eff_len) && hit;
    assign take      = counted && (r_seen == r_wanted || r_wanted == '0);
    assign emit      = take || (r_in_final && !r_reported);
    assign start_pos = r_pos - POSITION_BITS'(eff_len - LEN_W'(1));
    assign n_addr    = r_base + ADDR_W'(start_pos)
                     + {{(ADDR_W-OFFSET_W){r_offset[OFFSET_W-1]}}, r_offset};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_data_byte;
            r_in_final <= i_final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_window[0] <= r_in_byte;
            for (int k = 1; k < WIN_D; k++) begin
                r_window[k] <= r_window[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_pos      <= '0;
            r_seen     <= '0;
            r_reported <= 1'b0;
        end else if (advance) begin
            if (r_in_final) begin
                r_fill     <= '0;
                r_pos      <= '0;
                r_seen     <= '0;
                r_reported <= 1'b0;
            end else begin
                r_fill <= n_fill;
                r_pos  <= r_pos + POSITION_BITS'(1);
                if (take) begin
                    r_reported <= 1'b1;
                end else if (counted && r_seen != '1) begin
                    r_seen <= r_seen + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_found <= take;
            r_addr  <= take ? n_addr : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_match_address = r_addr;

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_match_address == '0)
        else $error("not-found result with nonzero address");

    a_single_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_reported |-> !take)
        else $error("second report within one image");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= MAX_PATTERN)
        else $error("window fill count out of range");

endmodule
